// ===== rtl/core/hsl_to_rgb_converter_top_macros.svh =====
// assertion macros used by the hsl to rgb converter checker
`ifndef HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH

// generic property on aclk, masked while aresetn is low
`define HSLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// a stalled transaction keeps its valid and payload
`define HSLR_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

// ===== rtl/core/hslr_pkg.sv =====
// package: widths, types and helpers of the hsl to rgb converter
package hslr_pkg;

    localparam int HUE_BITS  = 12;
    localparam int CH_W      = 8;
    localparam int SAT_LSB   = HUE_BITS;
    localparam int LIGHT_LSB = HUE_BITS + CH_W;
    localparam int S_TDATA_W = ((HUE_BITS + 2 * CH_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 3 * CH_W;
    localparam int H6_W      = HUE_BITS + 3;
    localparam int DIFF_W    = CH_W + 1;
    localparam int SCALED_W  = DIFF_W + HUE_BITS;
    localparam int VAL_W     = CH_W + 3;

    typedef logic signed [VAL_W-1:0] val_t;

    // hue sextants, named by the pair of primaries they sweep between
    typedef enum logic [2:0] {
        SEXT_R_TO_Y = 3'd0,
        SEXT_Y_TO_G = 3'd1,
        SEXT_G_TO_C = 3'd2,
        SEXT_C_TO_B = 3'd3,
        SEXT_B_TO_M = 3'd4,
        SEXT_M_TO_R = 3'd5
    } sext_t;

    typedef struct packed {
        val_t                peak;
        val_t                base;
        logic [SCALED_W-1:0] scaled;
        sext_t               sext;
        logic                gray;
        logic [CH_W-1:0]     light;
    } mix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // floor(x / 255) for x up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
        logic [2*CH_W:0] t;
        t = {1'b0, x} + {{(CH_W+1){1'b0}}, x[2*CH_W-1:CH_W]} + {{(2*CH_W){1'b0}}, 1'b1};
        return t[2*CH_W-1:CH_W];
    endfunction

    function automatic logic [CH_W-1:0] clamp8(input val_t x);
        logic [CH_W-1:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > val_t'(255)) begin
            r = 8'd255;
        end else begin
            r = x[CH_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/hslr_mix.sv =====
// final stage logic: mid values, sextant routing and clamping
module hslr_mix
    import hslr_pkg::*;
(
    input  mix_in_t mix_in,
    output rgb_t    rgb
);

    val_t vsf;
    val_t mid1;
    val_t mid2;
    val_t r;
    val_t g;
    val_t b;
    val_t lv;

    assign vsf  = val_t'(mix_in.scaled[SCALED_W-1:HUE_BITS]);
    assign mid1 = mix_in.base + vsf;
    assign mid2 = mix_in.peak - vsf;
    assign lv   = val_t'({1'b0, mix_in.light});

    always_comb begin
        r = mix_in.peak;
        g = mix_in.base;
        b = mid2;
        if (mix_in.gray) begin
            r = lv;
            g = lv;
            b = lv;
        end else begin
            case (mix_in.sext)
                SEXT_R_TO_Y: begin
                    r = mix_in.peak; g = mid1;        b = mix_in.base;
                end
                SEXT_Y_TO_G: begin
                    r = mid2;        g = mix_in.peak; b = mix_in.base;
                end
                SEXT_G_TO_C: begin
                    r = mix_in.base; g = mix_in.peak; b = mid1;
                end
                SEXT_C_TO_B: begin
                    r = mix_in.base; g = mid2;        b = mix_in.peak;
                end
                SEXT_B_TO_M: begin
                    r = mid1;        g = mix_in.base; b = mix_in.peak;
                end
                SEXT_M_TO_R: begin
                    r = mix_in.peak; g = mix_in.base; b = mid2;
                end
                default: begin
                    r = mix_in.peak; g = mix_in.base; b = mid2;
                end
            endcase
        end
    end

    assign rgb.red   = clamp8(r);
    assign rgb.green = clamp8(g);
    assign rgb.blue  = clamp8(b);

endmodule

// ===== rtl/core/hsl_to_rgb_converter_top.sv =====
// top level: four-stage pipelined hsl to rgb color converter
// an input transaction moves through the p1, p2, p3 and out_reg stage registers in order to m_tvalid
// throughput: one transaction per cycle while m_tready is high, set by the four-stage register pipeline
// stalls on m_tready back up stage by stage; empty stages still accept new items
// reset: aresetn low clears all stage valid bits synchronously, payload is not reset
module hsl_to_rgb_converter_top
    import hslr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // hue, saturation, lightness, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // red, green, blue
);

    // input fields
    logic [HUE_BITS-1:0] s_hue;
    logic [CH_W-1:0]     s_sat;
    logic [CH_W-1:0]     s_light;

    assign s_hue   = s_tdata[HUE_BITS-1:0];
    assign s_sat   = s_tdata[SAT_LSB +: CH_W];
    assign s_light = s_tdata[LIGHT_LSB +: CH_W];

    // stage valid bits and per-stage load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // a stage may load when it is empty or its content moves on this cycle
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_tready = rdy1;

    assign v1_next = rdy1 ? s_tvalid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;
    assign v4_next = rdy4 ? v3_reg   : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // stage 1: l*s product and hue times six
    logic [2*CH_W-1:0] p1_prod_reg,  p1_prod_next;
    logic [H6_W-1:0]   p1_h6_reg,    p1_h6_next;
    logic [CH_W-1:0]   p1_sat_reg;
    logic [CH_W-1:0]   p1_light_reg;

    assign p1_prod_next = (2*CH_W)'(s_light) * (2*CH_W)'(s_sat);
    // 6h as 4h + 2h
    assign p1_h6_next = {1'b0, s_hue, 2'b00} + {2'b00, s_hue, 1'b0};

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            p1_prod_reg  <= p1_prod_next;
            p1_h6_reg    <= p1_h6_next;
            p1_sat_reg   <= s_sat;
            p1_light_reg <= s_light;
        end
    end

    // stage 2: peak, base and their spread
    logic [CH_W-1:0]     ls;
    val_t                l_val, s_val, ls_val;
    val_t                p2_peak_reg,  p2_peak_next;
    val_t                p2_base_reg,  p2_base_next;
    val_t                spread;
    logic [DIFF_W-1:0]   p2_diff_reg,  p2_diff_next;
    sext_t               p2_sext_reg;
    logic [HUE_BITS-1:0] p2_fract_reg;
    logic                p2_gray_reg,  p2_gray_next;
    logic [CH_W-1:0]     p2_light_reg;

    assign ls     = div255(p1_prod_reg);
    assign l_val  = val_t'({1'b0, p1_light_reg});
    assign s_val  = val_t'({1'b0, p1_sat_reg});
    assign ls_val = val_t'({1'b0, ls});

    // threshold of half lightness is l <= 127, i.e. msb clear
    assign p2_peak_next = p1_light_reg[CH_W-1] ? (l_val + s_val - ls_val) : (l_val + ls_val);
    assign p2_base_next = l_val + l_val - p2_peak_next;
    assign spread       = p2_peak_next - p2_base_next;
    assign p2_diff_next = (spread < 0) ? '0 : spread[DIFF_W-1:0];
    // zero peak gives gray
    assign p2_gray_next = (p2_peak_next <= 0);

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            p2_peak_reg  <= p2_peak_next;
            p2_base_reg  <= p2_base_next;
            p2_diff_reg  <= p2_diff_next;
            p2_sext_reg  <= sext_t'(p1_h6_reg[H6_W-1:HUE_BITS]);
            p2_fract_reg <= p1_h6_reg[HUE_BITS-1:0];
            p2_gray_reg  <= p2_gray_next;
            p2_light_reg <= p1_light_reg;
        end
    end

    // stage 3: spread times hue fraction
    mix_in_t p3_reg, p3_next;

    always_comb begin
        p3_next.peak   = p2_peak_reg;
        p3_next.base   = p2_base_reg;
        p3_next.scaled = SCALED_W'(p2_diff_reg) * SCALED_W'(p2_fract_reg);
        p3_next.sext   = p2_sext_reg;
        p3_next.gray   = p2_gray_reg;
        p3_next.light  = p2_light_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            p3_reg <= p3_next;
        end
    end

    // stage 4: mid values and routing into the output register
    rgb_t out_reg, out_next;

    hslr_mix u_mix (
        .mix_in (p3_reg),
        .rgb    (out_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red};

endmodule

// ===== rtl/core/hslr_check.sv =====
// port checker of the hsl to rgb converter and its bind
`include "hsl_to_rgb_converter_top_macros.svh"

module hslr_check
    import hslr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    `HSLR_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata, "output changed while stalled")

    // free-flowing output shows a valid result once the transaction has passed every pipeline stage
    `HSLR_ASSERT(a_latency, (s_acc && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid, "result missing after pipeline latency")

    // zero lightness gives black
    `HSLR_ASSERT(a_black, (s_acc && m_tready && s_tdata[LIGHT_LSB +: CH_W] == '0) ##1 m_tready ##1 m_tready ##1 m_tready |=> (m_tdata == '0), "zero lightness not black")

    // zero saturation gives gray at the input lightness
    `HSLR_ASSERT(a_gray, (s_acc && m_tready && s_tdata[SAT_LSB +: CH_W] == '0) ##1 m_tready ##1 m_tready ##1 m_tready |=> (m_tdata[CH_W-1:0] == $past(s_tdata[LIGHT_LSB +: CH_W], 4) && m_tdata[CH_W +: CH_W] == m_tdata[CH_W-1:0] && m_tdata[2*CH_W +: CH_W] == m_tdata[CH_W-1:0]), "zero saturation not gray")

endmodule

bind hsl_to_rgb_converter_top hslr_check u_hslr_check (.*);

// ===== sim/tb_top.sv =====
// testbench for the hsl to rgb converter: directed and random pixels, scoreboard check
module tb_top
    import hslr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // keeps the predicted colors of accepted pixels and compares the results in order
    class rgb_scoreboard;
        rgb_t pending_rgb[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [CH_W-1:0] clamp_channel(int x);
            logic [CH_W-1:0] c;
            if (x < 0) begin
                c = '0;
            end else if (x > 255) begin
                c = 8'd255;
            end else begin
                c = x[CH_W-1:0];
            end
            return c;
        endfunction

        static function rgb_t hsl_to_rgb(logic [HUE_BITS-1:0] hue, logic [CH_W-1:0] sat,
                                         logic [CH_W-1:0] light);
            int          l, s, ls, v, m, diff, vsf, mid1, mid2, r, g, b;
            int unsigned h6, fract;
            sext_t       sext;
            rgb_t        res;
            l  = light;
            s  = sat;
            ls = (l * s) / 255;
            v  = (l <= 127) ? (l + ls) : (l + s - ls);
            r  = l;
            g  = l;
            b  = l;
            // zero peak leaves the gray value
            if (v > 0) begin
                m     = 2 * l - v;
                h6    = int'(hue) * 6;
                sext  = sext_t'(h6 >> HUE_BITS);
                fract = h6 & ((1 << HUE_BITS) - 1);
                diff  = v - m;
                if (diff < 0) begin
                    diff = 0;
                end
                vsf  = int'((diff * fract) >> HUE_BITS);
                mid1 = m + vsf;
                mid2 = v - vsf;
                case (sext)
                    SEXT_R_TO_Y: begin r = v;    g = mid1; b = m;    end
                    SEXT_Y_TO_G: begin r = mid2; g = v;    b = m;    end
                    SEXT_G_TO_C: begin r = m;    g = v;    b = mid1; end
                    SEXT_C_TO_B: begin r = m;    g = mid2; b = v;    end
                    SEXT_B_TO_M: begin r = mid1; g = m;    b = v;    end
                    default:     begin r = v;    g = m;    b = mid2; end
                endcase
            end
            res.red   = clamp_channel(r);
            res.green = clamp_channel(g);
            res.blue  = clamp_channel(b);
            return res;
        endfunction

        function void note_pixel(logic [HUE_BITS-1:0] hue, logic [CH_W-1:0] sat,
                                 logic [CH_W-1:0] light);
            pending_rgb.push_back(hsl_to_rgb(hue, sat, light));
        endfunction

        function void check_color(logic [M_TDATA_W-1:0] tdata);
            rgb_t want;
            if (pending_rgb.size() == 0) begin
                $error("unexpected color transaction 0x%06h", tdata);
                mismatches++;
                return;
            end
            want = pending_rgb.pop_front();
            if (tdata[7:0] !== want.red) begin
                $error("red mismatch: expected %0d, actual %0d", want.red, tdata[7:0]);
                mismatches++;
            end
            if (tdata[15:8] !== want.green) begin
                $error("green mismatch: expected %0d, actual %0d", want.green, tdata[15:8]);
                mismatches++;
            end
            if (tdata[23:16] !== want.blue) begin
                $error("blue mismatch: expected %0d, actual %0d", want.blue, tdata[23:16]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // hue, saturation, lightness, zero pad
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // red, green, blue

    // no idling on either side once this is set
    bit steady_phase = 1'b0;

    rgb_scoreboard sb = new();

    hsl_to_rgb_converter_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // one pixel transaction; the sender may idle for a random burst afterwards
    task automatic send_pixel(input logic [HUE_BITS-1:0] hue, input logic [CH_W-1:0] sat,
                              input logic [CH_W-1:0] light);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({light, sat, hue});
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_pixel(hue, sat, light);
        if (!steady_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // hold off the sender until every predicted color has come back
    task automatic drain_colors();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_rgb.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // channel value biased toward the ends and the half-lightness threshold
    function automatic logic [CH_W-1:0] pick_channel();
        logic [CH_W-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = 8'd0;
            1:       c = 8'd255;
            2:       c = 8'd127;
            3:       c = 8'd128;
            4:       c = CH_W'($urandom_range(0, 3));
            default: c = CH_W'($urandom);
        endcase
        return c;
    endfunction

    // hue biased toward the sextant boundaries and the wrap point
    function automatic logic [HUE_BITS-1:0] pick_hue();
        int k;
        int h;
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 5);
            h = (k * (1 << HUE_BITS) + 5) / 6 + $urandom_range(0, 4) - 2;
            return HUE_BITS'(h);
        end
        return HUE_BITS'($urandom);
    endfunction

    // result side: random stall bursts while not in the steady phase
    initial begin
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (!steady_phase && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // every accepted color transaction goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_color(m_tdata);
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: gray black, full white, the lightness threshold, sextant edges
        send_pixel(12'd0,    8'd0,   8'd0);
        send_pixel(12'd4095, 8'd255, 8'd0);
        send_pixel(12'd4095, 8'd255, 8'd255);
        send_pixel(12'd0,    8'd0,   8'd255);
        send_pixel(12'd0,    8'd255, 8'd127);
        send_pixel(12'd0,    8'd255, 8'd128);
        send_pixel(12'd682,  8'd255, 8'd127);
        send_pixel(12'd683,  8'd255, 8'd128);
        send_pixel(12'd1365, 8'd200, 8'd64);
        send_pixel(12'd1366, 8'd200, 8'd64);
        send_pixel(12'd2047, 8'd255, 8'd127);
        send_pixel(12'd2048, 8'd255, 8'd127);
        send_pixel(12'd2730, 8'd128, 8'd200);
        send_pixel(12'd2731, 8'd128, 8'd200);
        send_pixel(12'd3413, 8'd255, 8'd1);
        send_pixel(12'd3414, 8'd255, 8'd1);
        send_pixel(12'd4095, 8'd255, 8'd128);
        send_pixel(12'd1,    8'd1,   8'd254);
        send_pixel(12'd2500, 8'd255, 8'd255);
        send_pixel(12'd3900, 8'd17,  8'd1);
        send_pixel(12'd0,    8'd255, 8'd0);
        drain_colors();

        // random pixels with the sender held off once midway
        for (int i = 0; i < 1300; i++) begin
            if (i == 650) begin
                drain_colors();
            end
            if (i == 1100) begin
                steady_phase = 1'b1;
            end
            send_pixel(pick_hue(), pick_channel(), pick_channel());
        end
        s_tvalid <= 1'b0;

        while (sb.pending_rgb.size() != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
